// File: sv/byte_escape_codec_top_macros.svh
// ----------------------------------------------------------------------------
// byte_escape_codec_top assertion macros
// Clocked, reset-qualified property wrappers for the codec checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_ESCAPE_CODEC_TOP_MACROS_SVH
`define BYTE_ESCAPE_CODEC_TOP_MACROS_SVH

// same-cycle implication
`define BEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("byte_escape_codec_top: assertion failed");

// next-cycle implication
`define BEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("byte_escape_codec_top: assertion failed");

`endif

// File: sv/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types and constants of the byte escape codec.
// ----------------------------------------------------------------------------
package bec_pkg;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] RegModeDecode = 2'd0;
  localparam logic [1:0] RegTokenByte  = 2'd1;
  localparam logic [1:0] RegEscapeByte = 2'd2;

  localparam logic       ModeDecodeRst = 1'b0;
  localparam logic [7:0] TokenByteRst  = 8'd126;
  localparam logic [7:0] EscapeByteRst = 8'd125;

  // follow codes of a two-byte sequence
  localparam logic [7:0] CodeEscape = 8'h01;
  localparam logic [7:0] CodeToken  = 8'h02;

  typedef struct packed {
    logic       mode_decode;
    logic [7:0] token_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_escape;
  } result_t;

  // results caused by one input item: count 0, 1 or 2, first in res0
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } res_pair_t;

endpackage

// File: sv/bec_in_if.sv
// ----------------------------------------------------------------------------
// bec_in_if
// Input byte channel: valid/ready handshake with one payload byte.
// ----------------------------------------------------------------------------
interface bec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// File: sv/bec_out_if.sv
// ----------------------------------------------------------------------------
// bec_out_if
// Output byte channel: valid/ready handshake with one coded byte.
// ----------------------------------------------------------------------------
interface bec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       bad_escape;

  modport source (output valid, output out_byte, output out_last, output bad_escape,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input bad_escape,
                  output ready);
endinterface

// File: sv/bec_cfg_regs.sv
// ----------------------------------------------------------------------------
// bec_cfg_regs
// APB-style register file holding mode, token byte and escape byte.
// ----------------------------------------------------------------------------
module bec_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bec_pkg::AddrWidth-1:0] paddr,
  input  logic [bec_pkg::DataWidth-1:0] pwdata,
  output logic [bec_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output bec_pkg::cfg_t                 cfg_o
);

  bec_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        bec_pkg::RegModeDecode: cfg_d.mode_decode = pwdata[0];
        bec_pkg::RegTokenByte:  cfg_d.token_byte  = pwdata[7:0];
        bec_pkg::RegEscapeByte: cfg_d.escape_byte = pwdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_decode <= bec_pkg::ModeDecodeRst;
      cfg_q.token_byte  <= bec_pkg::TokenByteRst;
      cfg_q.escape_byte <= bec_pkg::EscapeByteRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      bec_pkg::RegModeDecode: prdata = {{(bec_pkg::DataWidth-1){1'b0}}, cfg_q.mode_decode};
      bec_pkg::RegTokenByte:  prdata = {{(bec_pkg::DataWidth-8){1'b0}}, cfg_q.token_byte};
      bec_pkg::RegEscapeByte: prdata = {{(bec_pkg::DataWidth-8){1'b0}}, cfg_q.escape_byte};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/bec_core.sv
// ----------------------------------------------------------------------------
// bec_core
// Byte mapping for encode and decode, with the escape pending flag.
// ----------------------------------------------------------------------------
module bec_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bec_pkg::cfg_t        cfg_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_packet_i,
  output bec_pkg::res_pair_t   pair_o
);

  logic pending_q, pending_d;

  always_comb begin
    pair_o       = '0;
    pending_d    = pending_q;
    pair_o.count = 2'd1;
    pair_o.res0  = '{out_byte: data_byte_i, out_last: end_of_packet_i, bad_escape: 1'b0};
    if (!cfg_i.mode_decode) begin
      pending_d = 1'b0;
      // token test first: it wins when token and escape are equal
      if (data_byte_i == cfg_i.token_byte) begin
        pair_o.count = 2'd2;
        pair_o.res0  = '{out_byte: cfg_i.escape_byte, out_last: 1'b0, bad_escape: 1'b0};
        pair_o.res1  = '{out_byte: bec_pkg::CodeToken, out_last: end_of_packet_i,
                         bad_escape: 1'b0};
      end else if (data_byte_i == cfg_i.escape_byte) begin
        pair_o.count = 2'd2;
        pair_o.res0  = '{out_byte: cfg_i.escape_byte, out_last: 1'b0, bad_escape: 1'b0};
        pair_o.res1  = '{out_byte: bec_pkg::CodeEscape, out_last: end_of_packet_i,
                         bad_escape: 1'b0};
      end
    end else if (pending_q) begin
      pending_d = 1'b0;
      if (data_byte_i == bec_pkg::CodeEscape) begin
        pair_o.res0.out_byte = cfg_i.escape_byte;
      end else if (data_byte_i == bec_pkg::CodeToken) begin
        pair_o.res0.out_byte = cfg_i.token_byte;
      end else begin
        pair_o.res0.bad_escape = 1'b1;  // echo the unknown follow byte
      end
    end else if (data_byte_i == cfg_i.escape_byte) begin
      if (end_of_packet_i) begin
        pair_o.res0.bad_escape = 1'b1;  // escape with no follow byte
      end else begin
        pair_o.count = 2'd0;
        pending_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (accept_i) begin
      pending_q <= pending_d;
    end
  end

endmodule

// File: sv/bec_out_buf.sv
// ----------------------------------------------------------------------------
// bec_out_buf
// Two-slot result register feeding the output channel.
// ----------------------------------------------------------------------------
module bec_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bec_pkg::res_pair_t pair_i,
  output logic               can_load_o,
  bec_out_if.source          out_o
);

  bec_pkg::result_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign pop        = out_o.valid & out_o.ready;
  // take a new item only when the buffer is empty or drains this cycle
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
    if (load_i && (pair_i.count != 2'd0)) begin
      slot0_d = pair_i.res0;
      slot1_d = pair_i.res1;
      cnt_d   = pair_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_byte   = slot0_q.out_byte;
  assign out_o.out_last   = slot0_q.out_last;
  assign out_o.bad_escape = slot0_q.bad_escape;

endmodule

// File: sv/byte_escape_codec_top.sv
// ----------------------------------------------------------------------------
// byte_escape_codec_top
// Byte-stuffing encoder/decoder for a framed serial link.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one payload byte per transaction with an end_of_packet mark;
//   out_o carries coded bytes with out_last and bad_escape.
//   The APB port sets mode_decode (0x0), token_byte (0x4) and escape_byte (0x8);
//   write it only while no results are outstanding.
// Latency: a result appears on out_o the cycle after its input transaction.
// Throughput: one input byte per cycle while out_o.ready is high; a byte that
//   encodes to an escape pair fills both result slots, and the next input waits
//   until the pair's second byte is taken. A decode escape byte gives no result.
// Stall: the result register holds its bytes while out_o.ready is low, and
//   in_i.ready falls until the last held result is being taken.
// Reset: the result register empties, the escape pending flag clears, and the
//   registers return to encode mode, token 126, escape 125.
// ----------------------------------------------------------------------------
module byte_escape_codec_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bec_in_if.sink                        in_i,
  bec_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bec_pkg::AddrWidth-1:0] paddr,
  input  logic [bec_pkg::DataWidth-1:0] pwdata,
  output logic [bec_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  bec_pkg::cfg_t      cfg;
  bec_pkg::res_pair_t pair;
  logic               can_load;
  logic               accept;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid & can_load;

  bec_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bec_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .data_byte_i     (in_i.data_byte),
    .end_of_packet_i (in_i.end_of_packet),
    .pair_o          (pair)
  );

  bec_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .pair_i     (pair),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

// File: sv/bec_checker.sv
// ----------------------------------------------------------------------------
// bec_checker
// Port-level checks of the codec's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_escape_codec_top_macros.svh"

module bec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       bad_escape
);

  // a held result keeps its bytes
  `BEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(out_last) && $stable(bad_escape))

  // a stalled output blocks new input transactions
  `BEC_ASSERT_SAME(a_stall_blocks_in, out_valid && !out_ready, !in_ready)

  // with nothing held the block is ready for input
  `BEC_ASSERT_SAME(a_empty_ready, !out_valid, in_ready)

  // leaving reset the result register is empty
  `BEC_ASSERT_SAME(a_reset_empty, !$past(rst_ni), !out_valid)

endmodule

bind byte_escape_codec_top bec_checker u_bec_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_byte   (out_o.out_byte),
  .out_last   (out_o.out_last),
  .bad_escape (out_o.bad_escape)
);
